@@ hw/rtl/rclc_pkg.sv @@
`timescale 1ns / 1ps

package rclc_pkg;

  localparam int unsigned NumCmds    = 11;
  localparam int unsigned NameMaxLen = 7;
  localparam int unsigned PosWidth   = 3;
  localparam int unsigned IdxWidth   = 4;
  localparam int unsigned TallyWidth = 3;

  // parse phases
  localparam logic [1:0] PhaseName   = 2'd0;
  localparam logic [1:0] PhaseArgs   = 2'd1;
  localparam logic [1:0] PhaseClosed = 2'd2;

  // result status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusMalformed = 2'd1;
  localparam logic [1:0] StatusUnknown   = 2'd2;

  // characters with a role in the grammar
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // names padded with blanks to the maximum length, first character in the top byte
  localparam logic [NameMaxLen*8-1:0] CmdText [NumCmds] = '{
    "START  ", "STOP   ", "SPEED  ", "ACCEL  ", "GRAB   ",
    "MOVE.Q ", "MOVEJ.Q", "MOVEL.Q", "MOVE.P ", "MOVEJ.P", "MOVEL.P"
  };
  localparam logic [PosWidth-1:0] CmdLen [NumCmds] = '{
    3'd5, 3'd4, 3'd5, 3'd5, 3'd4, 3'd6, 3'd7, 3'd7, 3'd6, 3'd7, 3'd7
  };
  localparam logic [TallyWidth-1:0] CmdArgs [NumCmds] = '{
    3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };
  localparam logic [NumCmds-1:0] CmdCart = 11'b111_0000_0000;

  typedef struct packed {
    logic [1:0]            phase;
    logic [PosWidth-1:0]   name_pos;
    logic                  name_ovf;
    logic [NumCmds-1:0]    cand;
    logic                  tok_open;
    logic [TallyWidth-1:0] tally;
    logic                  malformed;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:     PhaseName,
    name_pos:  '0,
    name_ovf:  1'b0,
    cand:      '1,
    tok_open:  1'b0,
    tally:     '0,
    malformed: 1'b0
  };

  typedef struct packed {
    logic [1:0]            status;
    logic [IdxWidth-1:0]   command_index;
    logic                  cartesian_target;
    logic [TallyWidth-1:0] argument_count;
  } verdict_t;

  function automatic logic [7:0] cmd_char(input int unsigned k, input logic [PosWidth-1:0] pos);
    return CmdText[k][(NameMaxLen - 1 - int'(pos)) * 8 +: 8];
  endfunction

endpackage

@@ hw/rtl/rclc_char_if.sv @@
`timescale 1ns / 1ps

interface rclc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

@@ hw/rtl/rclc_result_if.sv @@
`timescale 1ns / 1ps

interface rclc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] command_index;
  logic       cartesian_target;
  logic [2:0] argument_count;

  modport source (output valid, output status, output command_index,
                  output cartesian_target, output argument_count, input ready);
  modport sink (input valid, input status, input command_index,
                input cartesian_target, input argument_count, output ready);
endinterface

@@ hw/rtl/rclc_name_match.sv @@
`timescale 1ns / 1ps

module rclc_name_match import rclc_pkg::*; (
  input  logic [7:0]          char_i,
  input  logic [PosWidth-1:0] pos_i,
  input  logic                ovf_i,
  input  logic [NumCmds-1:0]  cand_i,
  output logic [NumCmds-1:0]  char_cand_o,
  output logic [NumCmds-1:0]  done_cand_o
);

  always_comb begin
    for (int unsigned k = 0; k < NumCmds; k++) begin
      // one more name character: keep names that are long enough and agree here
      char_cand_o[k] = cand_i[k] && (pos_i < CmdLen[k]) && (cmd_char(k, pos_i) == char_i);
      // name closed by the bracket: keep names of exactly this length
      done_cand_o[k] = cand_i[k] && !ovf_i && (CmdLen[k] == pos_i);
    end
  end

endmodule

@@ hw/rtl/rclc_verdict.sv @@
`timescale 1ns / 1ps

module rclc_verdict import rclc_pkg::*; (
  input  parse_state_t state_i,
  output verdict_t     verdict_o
);

  logic                found;
  logic [IdxWidth-1:0] found_idx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = NumCmds - 1; k >= 0; k--) begin
      if (state_i.cand[k]) begin
        found     = 1'b1;
        found_idx = IdxWidth'(k);
      end
    end
  end

  always_comb begin
    verdict_o = '0;
    if (state_i.malformed || state_i.phase != PhaseClosed) begin
      verdict_o.status = StatusMalformed;
    end else begin
      verdict_o.argument_count = state_i.tally;
      if (!found || CmdArgs[found_idx] != state_i.tally) begin
        verdict_o.status = StatusUnknown;
      end else begin
        verdict_o.status           = StatusOk;
        verdict_o.command_index    = found_idx;
        verdict_o.cartesian_target = CmdCart[found_idx];
      end
    end
  end

endmodule

@@ hw/rtl/robot_command_line_checker.sv @@
`timescale 1ns / 1ps

// Checks one robot command line, e.g. MOVEJ.P(1.5, 2, 3, 4), one character per
// transaction on char_i; line_end marks the final character. A result leaves on
// result_o once per line, after the final character: status 0 with the command
// index and the cartesian flag, 1 for malformed text, 2 for an unknown name or a
// wrong argument count. The block takes one character every clock cycle unless
// stalled; a final character waits in the input register and its verdict is then
// registered into the result register. Characters keep flowing while a result waits;
// only a further final character stalls until the pending result is taken.
module robot_command_line_checker import rclc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  rclc_char_if.sink      char_i,
  rclc_result_if.source  result_o
);

  logic         s1_valid_q;
  logic [7:0]   s1_char_q;
  logic         s1_last_q;
  logic         s1_go;

  parse_state_t state_q, state_d, state_step;
  logic [NumCmds-1:0] char_cand, done_cand;
  verdict_t     verdict;

  logic         out_valid_q, out_valid_d;
  verdict_t     out_q;

  // a final character needs the result slot free or emptying
  assign s1_go = s1_valid_q && (!s1_last_q || !out_valid_q || result_o.ready);
  assign char_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      s1_char_q <= char_i.char_code;
      s1_last_q <= char_i.line_end;
    end
  end

  rclc_name_match u_name_match (
    .char_i      (s1_char_q),
    .pos_i       (state_q.name_pos),
    .ovf_i       (state_q.name_ovf),
    .cand_i      (state_q.cand),
    .char_cand_o (char_cand),
    .done_cand_o (done_cand)
  );

  always_comb begin
    state_step = state_q;
    unique case (state_q.phase)
      PhaseName: begin
        if (s1_char_q == ChOpen) begin
          state_step.cand  = done_cand;
          state_step.phase = PhaseArgs;
        end else if (s1_char_q == ChClose) begin
          state_step.malformed = 1'b1;
        end else if (state_q.name_pos == PosWidth'(NameMaxLen)) begin
          state_step.name_ovf = 1'b1;
          state_step.cand     = '0;
        end else begin
          state_step.cand     = char_cand;
          state_step.name_pos = state_q.name_pos + 1'b1;
        end
      end
      PhaseArgs: begin
        if (s1_char_q == ChClose || s1_char_q == ChComma) begin
          if (state_q.tok_open && state_q.tally != '1) begin
            state_step.tally = state_q.tally + 1'b1;
          end
          state_step.tok_open = 1'b0;
          if (s1_char_q == ChClose) begin
            state_step.phase = PhaseClosed;
          end
        end else if (s1_char_q == ChSpace || s1_char_q == ChTab) begin
          state_step.tok_open = state_q.tok_open;
        end else if ((s1_char_q >= ChZero && s1_char_q <= ChNine) || s1_char_q == ChDot) begin
          state_step.tok_open = 1'b1;
        end else begin
          state_step.malformed = 1'b1;
        end
      end
      default: begin
        state_step.malformed = 1'b1;
      end
    endcase
  end

  rclc_verdict u_verdict (
    .state_i   (state_step),
    .verdict_o (verdict)
  );

  always_comb begin
    state_d = state_q;
    if (s1_go) begin
      state_d = s1_last_q ? StateReset : state_step;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !result_o.ready;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_q <= verdict;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.status           = out_q.status;
  assign result_o.command_index    = out_q.command_index;
  assign result_o.cartesian_target = out_q.cartesian_target;
  assign result_o.argument_count   = out_q.argument_count;

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go && s1_last_q))
    else $error("result raised without a final character");

  a_ok_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == StatusOk |-> out_q.command_index < IdxWidth'(NumCmds))
    else $error("accepted command index out of table");

  a_malformed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == StatusMalformed
      |-> out_q.command_index == '0 && out_q.argument_count == '0 && !out_q.cartesian_target)
    else $error("malformed result carries payload");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_char_q) && $stable(state_q))
    else $error("stalled character lost");

  a_state_reset_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> state_q == StateReset)
    else $error("parse state not cleared after line end");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rclc_pkg::*;

  typedef logic [7:0] line_t [$];

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } line_char_t;

  logic clk_i;
  logic rst_ni;

  rclc_char_if   chars ();
  rclc_result_if verdicts ();

  robot_command_line_checker DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (chars),
    .result_o (verdicts)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // command table kept independently of the rtl tables
  string       cmd_names [NumCmds] = '{"START", "STOP", "SPEED", "ACCEL", "GRAB",
                                       "MOVE.Q", "MOVEJ.Q", "MOVEL.Q",
                                       "MOVE.P", "MOVEJ.P", "MOVEL.P"};
  int unsigned cmd_arity [NumCmds] = '{0, 0, 1, 1, 1, 4, 4, 4, 4, 4, 4};

  line_char_t  pending_chars [$];
  verdict_t    verdicts_due [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fault_count = 0;

  // line parser state
  logic [1:0]         st_phase;
  int unsigned        st_name_len;
  bit                 st_name_long;
  logic [NumCmds-1:0] st_cands;
  bit                 st_token_live;
  logic [2:0]         st_tokens;
  bit                 st_bad;

  function automatic void clear_parse();
    st_phase      = PhaseName;
    st_name_len   = 0;
    st_name_long  = 1'b0;
    st_cands      = '1;
    st_token_live = 1'b0;
    st_tokens     = '0;
    st_bad        = 1'b0;
  endfunction

  function automatic void end_token();
    if (st_token_live && st_tokens != 3'd7) st_tokens = st_tokens + 3'd1;
    st_token_live = 1'b0;
  endfunction

  // returns 1 when the character closes a line, with the verdict in v
  function automatic bit parse_char(input logic [7:0] c, input logic last, output verdict_t v);
    int k;
    int found;
    found = -1;
    v = '0;
    case (st_phase)
      PhaseName: begin
        if (c == ChOpen) begin
          for (k = 0; k < NumCmds; k++)
            if (st_name_long || cmd_names[k].len() != st_name_len) st_cands[k] = 1'b0;
          st_phase = PhaseArgs;
        end else if (c == ChClose) begin
          st_bad = 1'b1;
        end else if (st_name_len >= NameMaxLen) begin
          st_name_long = 1'b1;
          st_cands = '0;
        end else begin
          for (k = 0; k < NumCmds; k++)
            if (st_name_len >= cmd_names[k].len() || cmd_names[k][st_name_len] != c)
              st_cands[k] = 1'b0;
          st_name_len++;
        end
      end
      PhaseArgs: begin
        if (c == ChClose) begin
          end_token();
          st_phase = PhaseClosed;
        end else if (c == ChComma) begin
          end_token();
        end else if (c == ChSpace || c == ChTab) begin
        end else if ((c >= ChZero && c <= ChNine) || c == ChDot) begin
          st_token_live = 1'b1;
        end else begin
          st_bad = 1'b1;
        end
      end
      default: st_bad = 1'b1;
    endcase
    if (!last) return 1'b0;
    if (st_bad || st_phase != PhaseClosed) begin
      v.status = StatusMalformed;
    end else begin
      for (k = NumCmds - 1; k >= 0; k--)
        if (st_cands[k]) found = k;
      v.argument_count = st_tokens;
      if (found < 0 || cmd_arity[found] != st_tokens) begin
        v.status = StatusUnknown;
      end else begin
        v.status = StatusOk;
        v.command_index = found[IdxWidth-1:0];
        for (k = 0; k + 1 < cmd_names[found].len(); k++)
          if (cmd_names[found][k] == ChDot && cmd_names[found][k+1] == "P")
            v.cartesian_target = 1'b1;
      end
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void report_fault(input string what, input verdict_t want,
                                       input verdict_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%t %s: expected status %0d index %0d cart %0d count %0d",
               $time, what, want.status, want.command_index, want.cartesian_target,
               want.argument_count);
      $display("  got status %0d index %0d cart %0d count %0d",
               got.status, got.command_index, got.cartesian_target, got.argument_count);
    end
  endfunction

  function automatic void check_verdict(input verdict_t got);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report_fault("result with no line pending", '0, got);
      return;
    end
    want = verdicts_due.pop_front();
    if (got.status != want.status || got.command_index != want.command_index ||
        got.cartesian_target != want.cartesian_target ||
        got.argument_count != want.argument_count)
      report_fault("verdict mismatch", want, got);
  endfunction

  // character driver
  verdict_t   accepted_verdict;
  line_char_t next_char;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars.valid     <= 1'b0;
      chars.char_code <= '0;
      chars.line_end  <= 1'b0;
      clear_parse();
    end else begin
      if (chars.valid && chars.ready) begin
        if (parse_char(chars.char_code, chars.line_end, accepted_verdict))
          verdicts_due = {verdicts_due, accepted_verdict};
      end
      if (!chars.valid || chars.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_char = pending_chars.pop_front();
          chars.valid     <= 1'b1;
          chars.char_code <= next_char.code;
          chars.line_end  <= next_char.last;
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  verdict_t seen_verdict;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdicts.ready <= 1'b0;
    end else begin
      if (verdicts.valid && verdicts.ready) begin
        seen_verdict.status           = verdicts.status;
        seen_verdict.command_index    = verdicts.command_index;
        seen_verdict.cartesian_target = verdicts.cartesian_target;
        seen_verdict.argument_count   = verdicts.argument_count;
        check_verdict(seen_verdict);
      end
      verdicts.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic line_t text(input string s);
    line_t l;
    int i;
    for (i = 0; i < s.len(); i++) l = {l, s[i]};
    return l;
  endfunction

  function automatic void queue_line(input line_t l);
    int i;
    line_char_t lc;
    for (i = 0; i < l.size(); i++) begin
      lc.code = l[i];
      lc.last = (i == l.size() - 1);
      pending_chars = {pending_chars, lc};
    end
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(1) ? ChSpace : ChTab;
  endfunction

  function automatic line_t clean_line(input int unsigned k);
    line_t       l;
    int unsigned n, t, j, len;
    logic [3:0]  d;
    l = text(cmd_names[k]);
    l = {l, ChOpen};
    // mostly the right count, sometimes any count up past saturation
    n = ($urandom_range(4) == 0) ? $urandom_range(9) : cmd_arity[k];
    for (t = 0; t < n; t++) begin
      if (t != 0) l = {l, ChComma};
      if ($urandom_range(6) == 0) l = {l, ChComma};
      if ($urandom_range(3) == 0) l = {l, blank()};
      len = $urandom_range(4, 1);
      for (j = 0; j < len; j++) begin
        d = 4'($urandom_range(10));
        l = {l, (d == 4'd10) ? ChDot : ChZero + d};
        if ($urandom_range(9) == 0) l = {l, blank()};
      end
      if ($urandom_range(3) == 0) l = {l, blank()};
    end
    l = {l, ChClose};
    return l;
  endfunction

  function automatic line_t random_line();
    line_t       l;
    int unsigned r, pos, len, i;
    logic [7:0]  grammar [8] = '{ChOpen, ChClose, ChComma, ChSpace, ChDot, ChZero, "S", "P"};
    r = $urandom_range(99);
    if (r < 70) begin
      l = clean_line($urandom_range(NumCmds - 1));
    end else if (r < 88) begin
      l = clean_line($urandom_range(NumCmds - 1));
      pos = $urandom_range(l.size() - 1);
      case ($urandom_range(3))
        0: l[pos] = 8'($urandom_range(255));
        1: l.insert(pos, 8'($urandom_range(255)));
        2: l.delete(pos);
        default: l = {l, grammar[$urandom_range(7)]};
      endcase
      if (l.size() == 0) l = {l, ChClose};
    end else begin
      len = $urandom_range(10, 1);
      for (i = 0; i < len; i++)
        l = {l, $urandom_range(1) ? grammar[$urandom_range(7)] : 8'($urandom_range(255))};
    end
    return l;
  endfunction

  // hold the sender until every line has been judged
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || chars.valid || verdicts_due.size() != 0);
  endtask

  int unsigned idle_plan  [4] = '{0, 62, 0, 27};
  int unsigned stall_plan [4] = '{0, 0, 62, 27};

  initial begin
    line_t       l;
    int unsigned p, sent, lines;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_line(text("START()"));
    queue_line(text("STOP()"));
    queue_line(text("SPEED(5)"));
    queue_line(text("ACCEL(.)"));
    queue_line(text("GRAB(9)"));
    queue_line(text("MOVE.Q(1,2,3,4)"));
    queue_line(text("MOVEJ.Q(0,0,0,0)"));
    queue_line(text("MOVEL.Q(1.5, 2,\t3 ,4)"));
    queue_line(text("MOVE.P(1,2,3,4)"));
    queue_line(text("MOVEJ.P(9,8,7,6)"));
    // blanks inside a token and an empty token
    queue_line(text("MOVEL.P(1 2,,3,4,5)"));
    queue_line(text("SPEED( ,7)"));
    queue_line(text(")STOP()"));
    queue_line(text("STOP"));
    queue_line(text("SPEED(1"));
    queue_line(text("STOP())"));
    queue_line(text("SPEED((1)"));
    queue_line(text("SPEED(a)"));
    queue_line(text("()"));
    queue_line(text("MOVEJ.QQ(1,2,3,4)"));
    queue_line(text("MOVE.Q(1,2,3,4,5,6,7,8,9)"));
    queue_line(text("SPEED(1,2)"));
    queue_line(text("start()"));
    // nul and high bytes in the name
    l = text("S");
    l = {l, 8'h00};
    l = {l, text("TOP()")};
    queue_line(l);
    l = '{8'hFF, 8'h80, ChOpen, ChClose};
    queue_line(l);
    queue_line(text(")"));
    queue_line(text("("));
    wait_drained();

    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      sent  = 0;
      lines = 0;
      while (sent < 60 || lines < 5) begin
        l = random_line();
        queue_line(l);
        sent += l.size();
        lines++;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
